FILE: rtl/dwts_pkg.sv
// Shared constants, types and helper functions of the DMA write splitter.
package dwts_pkg;

   localparam int ADDR_W        = 64;
   localparam int COUNT_W       = 13;
   localparam int LEN_W         = 6;
   localparam int BE_W          = 4;
   localparam int SRC_W         = 12;
   localparam int TAKEN_W       = 8;
   localparam int MAX_PAYLOAD   = 128;
   localparam int PAYLOAD_BITS  = 7;
   localparam int MAX_BYTES     = 4096;
   localparam int MAX_RESULTS   = 34;
   localparam int NCOUNT_W      = 6;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } dwts_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
   } dwts_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_empty;
      logic chunk_last;
   } dwts_sts_type;

   // Low n bytes enabled, with n of zero meaning a whole dword.
   function automatic logic [BE_W-1:0] tail_mask(input logic [1:0] n);
      logic [BE_W-1:0] m;
      unique case (n)
         2'd1:    m = 4'b0001;
         2'd2:    m = 4'b0011;
         2'd3:    m = 4'b0111;
         default: m = 4'b1111;
      endcase
      return m;
   endfunction

endpackage

FILE: rtl/dwts_req_if.sv
// Request channel carrying one write request per beat.
interface dwts_req_if;
   logic                              valid;
   logic                              ready;
   logic [dwts_pkg::ADDR_W-1:0]       start_address;
   logic [dwts_pkg::COUNT_W-1:0]      byte_count;

   modport source (output valid, output start_address, output byte_count, input ready);
   modport sink   (input valid, input start_address, input byte_count, output ready);
endinterface

FILE: rtl/dwts_rsp_if.sv
// Response channel carrying one chunk descriptor per beat.
interface dwts_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [dwts_pkg::ADDR_W-1:0]       chunk_address;
   logic [dwts_pkg::LEN_W-1:0]        length_dwords;
   logic [dwts_pkg::BE_W-1:0]         first_be;
   logic [dwts_pkg::BE_W-1:0]         last_be;
   logic [dwts_pkg::SRC_W-1:0]        source_offset;
   logic [dwts_pkg::TAKEN_W-1:0]      bytes_taken;
   logic                              wide_address;
   logic                              last_chunk;

   modport source (output valid, output chunk_address, output length_dwords,
                   output first_be, output last_be, output source_offset,
                   output bytes_taken, output wide_address, output last_chunk,
                   input ready);
   modport sink   (input valid, input chunk_address, input length_dwords,
                   input first_be, input last_be, input source_offset,
                   input bytes_taken, input wide_address, input last_chunk,
                   output ready);
endinterface

FILE: rtl/dwts_ctrl.sv
// Controller state machine sequencing request loads and chunk steps.
module dwts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   input  dwts_pkg::dwts_sts_type sts,
   output dwts_pkg::dwts_cmd_type cmd
);

   dwts_pkg::dwts_state_type state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == dwts_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load = req_valid && (state_ff == dwts_pkg::ST_IDLE);
      cmd.step = (state_ff == dwts_pkg::ST_BUSY) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dwts_pkg::ST_IDLE: begin
            if (cmd.load && !sts.req_empty) begin
               state_in = dwts_pkg::ST_BUSY;
            end
         end
         dwts_pkg::ST_BUSY: begin
            if (cmd.step && sts.chunk_last) begin
               state_in = dwts_pkg::ST_IDLE;
            end
         end
         default: state_in = dwts_pkg::ST_IDLE;
      endcase
   end

   // The output register empties on a taken beat and refills on each step.
   always_comb begin
      if (cmd.step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dwts_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/dwts_dp.sv
// Datapath holding the running address, count and offset, and the output register.
module dwts_dp (
   input  logic                                  clock,
   input  dwts_pkg::dwts_cmd_type                cmd,
   output dwts_pkg::dwts_sts_type                sts,
   input  logic [dwts_pkg::ADDR_W-1:0]           start_address,
   input  logic [dwts_pkg::COUNT_W-1:0]          byte_count,
   output logic [dwts_pkg::ADDR_W-1:0]           chunk_address,
   output logic [dwts_pkg::LEN_W-1:0]            length_dwords,
   output logic [dwts_pkg::BE_W-1:0]             first_be,
   output logic [dwts_pkg::BE_W-1:0]             last_be,
   output logic [dwts_pkg::SRC_W-1:0]            source_offset,
   output logic [dwts_pkg::TAKEN_W-1:0]          bytes_taken,
   output logic                                  wide_address,
   output logic                                  last_chunk
);

   localparam int RW = dwts_pkg::PAYLOAD_BITS + 1;

   logic [dwts_pkg::ADDR_W-1:0]    addr_ff, addr_in;
   logic [dwts_pkg::COUNT_W-1:0]   left_ff, left_in;
   logic [dwts_pkg::COUNT_W-1:0]   src_ff, src_in;
   logic [dwts_pkg::NCOUNT_W-1:0]  n_ff, n_in;
   logic [dwts_pkg::COUNT_W-1:0]   count_sat;

   logic [1:0]                     off;
   logic                           unaligned;
   logic [RW-1:0]                  room;
   logic [RW-1:0]                  take;
   logic [RW-1:0]                  take_p3;
   logic [dwts_pkg::BE_W-1:0]      lead_mask;
   logic [dwts_pkg::BE_W-1:0]      tmask;
   logic [dwts_pkg::ADDR_W-1:0]    addr_out;
   logic [dwts_pkg::LEN_W-1:0]     len_c;
   logic [dwts_pkg::BE_W-1:0]      fbe_c, lbe_c;
   logic                           last_c;

   always_comb begin
      if (byte_count > dwts_pkg::COUNT_W'(dwts_pkg::MAX_BYTES)) begin
         count_sat = dwts_pkg::COUNT_W'(dwts_pkg::MAX_BYTES);
      end else begin
         count_sat = byte_count;
      end
   end

   // Only the first chunk of a request can start off a dword boundary.
   always_comb begin
      off       = addr_ff[1:0];
      unaligned = (off != 2'd0);
      if (unaligned) begin
         room = RW'(3'd4 - {1'b0, off});
      end else begin
         room = RW'(dwts_pkg::MAX_PAYLOAD) - {1'b0, addr_ff[dwts_pkg::PAYLOAD_BITS-1:0]};
      end
      if (left_ff < dwts_pkg::COUNT_W'(room)) begin
         take = RW'(left_ff);
      end else begin
         take = room;
      end
      take_p3   = take + RW'(3);
      tmask     = dwts_pkg::tail_mask(take[1:0]);
      lead_mask = (left_ff < dwts_pkg::COUNT_W'(4)) ? dwts_pkg::tail_mask(left_ff[1:0])
                                                   : 4'hf;
      if (unaligned) begin
         addr_out = {addr_ff[dwts_pkg::ADDR_W-1:2], 2'b00};
         len_c    = dwts_pkg::LEN_W'(1);
         fbe_c    = lead_mask << off;
         lbe_c    = '0;
      end else if (take <= RW'(4)) begin
         addr_out = addr_ff;
         len_c    = dwts_pkg::LEN_W'(1);
         fbe_c    = tmask;
         lbe_c    = '0;
      end else begin
         addr_out = addr_ff;
         len_c    = dwts_pkg::LEN_W'(take_p3[RW-1:2]);
         fbe_c    = 4'hf;
         lbe_c    = tmask;
      end
      last_c = (left_ff == dwts_pkg::COUNT_W'(take)) ||
               ((7'(n_ff) + 7'd1) >= 7'(dwts_pkg::MAX_RESULTS));
   end

   always_comb begin
      sts.req_empty  = (count_sat == '0);
      sts.chunk_last = last_c;
   end

   always_comb begin
      addr_in = addr_ff;
      left_in = left_ff;
      src_in  = src_ff;
      n_in    = n_ff;
      if (cmd.load) begin
         addr_in = start_address;
         left_in = count_sat;
         src_in  = '0;
         n_in    = '0;
      end else if (cmd.step) begin
         addr_in = addr_ff + dwts_pkg::ADDR_W'(take);
         left_in = left_ff - dwts_pkg::COUNT_W'(take);
         src_in  = src_ff + dwts_pkg::COUNT_W'(take);
         n_in    = n_ff + dwts_pkg::NCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      left_ff <= left_in;
      src_ff  <= src_in;
      n_ff    <= n_in;
      if (cmd.step) begin
         chunk_address <= addr_out;
         length_dwords <= len_c;
         first_be      <= fbe_c;
         last_be       <= lbe_c;
         source_offset <= src_ff[dwts_pkg::SRC_W-1:0];
         bytes_taken   <= dwts_pkg::TAKEN_W'(take);
         wide_address  <= |addr_out[dwts_pkg::ADDR_W-1:32];
         last_chunk    <= last_c;
      end
   end

endmodule

FILE: rtl/dma_write_tlp_splitter.sv
// A taken request beat loads the datapath registers; the first chunk beat is then registered
// by a step. A request of N chunks (N from 1 to 34) occupies the block for its load and N steps,
// one chunk per cycle through the datapath's 64-bit address adder while the output register is
// empty or its beat is taken. A zero-byte request produces no beats.
// Reset (synchronous, active high) returns the controller to idle and empties the output
// register; there is no storage to clear.
module dma_write_tlp_splitter (
   input  logic              clock,
   input  logic              reset,
   dwts_req_if.sink          req_ch,
   dwts_rsp_if.source        rsp_ch
);

   // The controller only decides when to load a request and when to step out a chunk;
   // the datapath owns every address, count and byte-enable calculation.
   dwts_pkg::dwts_cmd_type cmd;
   dwts_pkg::dwts_sts_type sts;

   // Request beats are taken only while idle. The response side has a register of its
   // own, so a new request can be taken while the final chunk of the previous one is
   // still waiting to be collected.
   dwts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Each step writes one chunk descriptor into the output register and advances the
   // address, the remaining count and the source offset by the bytes that chunk carries.
   dwts_dp u_dp (
      .clock         (clock),
      .cmd           (cmd),
      .sts           (sts),
      .start_address (req_ch.start_address),
      .byte_count    (req_ch.byte_count),
      .chunk_address (rsp_ch.chunk_address),
      .length_dwords (rsp_ch.length_dwords),
      .first_be      (rsp_ch.first_be),
      .last_be       (rsp_ch.last_be),
      .source_offset (rsp_ch.source_offset),
      .bytes_taken   (rsp_ch.bytes_taken),
      .wide_address  (rsp_ch.wide_address),
      .last_chunk    (rsp_ch.last_chunk)
   );

   // A step always leaves a beat on offer in the following cycle.
   assert property (@(posedge clock) disable iff (reset) cmd.step |=> rsp_ch.valid)
      else $error("chunk step did not present a response beat");

   // Stepping out the final chunk frees the request side.
   assert property (@(posedge clock) disable iff (reset)
                    cmd.step && sts.chunk_last |=> req_ch.ready)
      else $error("request side not freed after final chunk");

   // A non-empty request blocks further requests until its chunks are out.
   assert property (@(posedge clock) disable iff (reset)
                    cmd.load && !sts.req_empty |=> !req_ch.ready)
      else $error("request accepted while a previous one is in progress");

   // Loading and stepping never coincide.
   assert property (@(posedge clock) disable iff (reset) !(cmd.load && cmd.step))
      else $error("load and step issued together");

endmodule

FILE: tb/dwts_chunk_checker.sv
// Chunk checker for the DMA write splitter: predicts the chunk beats of each request and compares.
`timescale 1ns / 100ps

module dwts_chunk_checker (
   input  logic clock,
   input  logic reset,
   dwts_req_if  req_mon,
   dwts_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending
);

   typedef struct packed {
      logic [dwts_pkg::ADDR_W-1:0]  chunk_address;
      logic [dwts_pkg::LEN_W-1:0]   length_dwords;
      logic [dwts_pkg::BE_W-1:0]    first_be;
      logic [dwts_pkg::BE_W-1:0]    last_be;
      logic [dwts_pkg::SRC_W-1:0]   source_offset;
      logic [dwts_pkg::TAKEN_W-1:0] bytes_taken;
      logic                         wide_address;
      logic                         last_chunk;
   } chunk_desc_type;

   chunk_desc_type expected_chunks[$];

   // Byte enables of the last dword of a run of n bytes; a multiple of four fills it.
   function automatic logic [dwts_pkg::BE_W-1:0] end_lanes(input int unsigned n);
      int unsigned r;
      r = n % 4;
      if (r == 0) return 4'hf;
      return 4'(4'hf >> (4 - r));
   endfunction

   function automatic chunk_desc_type make_chunk(input logic [dwts_pkg::ADDR_W-1:0] addr,
                                                 input int unsigned dwords,
                                                 input logic [dwts_pkg::BE_W-1:0] fbe,
                                                 input logic [dwts_pkg::BE_W-1:0] lbe,
                                                 input int unsigned src,
                                                 input int unsigned take,
                                                 input logic last);
      chunk_desc_type c;
      c.chunk_address = addr;
      c.length_dwords = dwts_pkg::LEN_W'(dwords);
      c.first_be      = fbe;
      c.last_be       = lbe;
      c.source_offset = dwts_pkg::SRC_W'(src);
      c.bytes_taken   = dwts_pkg::TAKEN_W'(take);
      c.wide_address  = |addr[dwts_pkg::ADDR_W-1:32];
      c.last_chunk    = last;
      return c;
   endfunction

   // Splits one write request into its chunks and queues them in order.
   function automatic void split_request(input logic [dwts_pkg::ADDR_W-1:0] start_addr,
                                         input logic [dwts_pkg::COUNT_W-1:0] count);
      logic [dwts_pkg::ADDR_W-1:0] addr;
      int unsigned                 left, src, take, room, inr, off;
      int                          n;
      logic                        last;
      logic [dwts_pkg::BE_W-1:0]   be;
      addr = start_addr;
      left = count;
      src  = 0;
      n    = 0;
      last = 1'b0;
      if (left > dwts_pkg::MAX_BYTES) left = dwts_pkg::MAX_BYTES;
      if (left == 0) return;
      if (addr[1:0] != 2'b00) begin
         // Unaligned head: one dword carrying the bytes up to the next boundary.
         off  = addr[1:0];
         room = 4 - off;
         take = (left < room) ? left : room;
         inr  = (left < 4) ? left : 4;
         be   = 4'(((32'd1 << inr) - 32'd1) << off);
         last = (left == take) || (n + 1 >= dwts_pkg::MAX_RESULTS);
         expected_chunks.push_back(make_chunk({addr[dwts_pkg::ADDR_W-1:2], 2'b00}, 1, be,
                                              4'h0, src, take, last));
         n++;
         src  += take;
         left -= take;
         addr += dwts_pkg::ADDR_W'(take);
      end
      while (left != 0 && !last) begin
         room = dwts_pkg::MAX_PAYLOAD -
                int'(addr % dwts_pkg::ADDR_W'(dwts_pkg::MAX_PAYLOAD));
         take = (left < room) ? left : room;
         be   = end_lanes(take);
         last = (left == take) || (n + 1 >= dwts_pkg::MAX_RESULTS);
         if (take <= 4)
            expected_chunks.push_back(make_chunk(addr, 1, be, 4'h0, src, take, last));
         else
            expected_chunks.push_back(make_chunk(addr, (take + 3) / 4, 4'hf, be,
                                                 src, take, last));
         n++;
         src  += take;
         left -= take;
         addr += dwts_pkg::ADDR_W'(take);
      end
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      chunk_desc_type got, want;
      if (reset) begin
         fail_count = 0;
         pending    = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            split_request(req_mon.start_address, req_mon.byte_count);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.chunk_address = rsp_mon.chunk_address;
            got.length_dwords = rsp_mon.length_dwords;
            got.first_be      = rsp_mon.first_be;
            got.last_be       = rsp_mon.last_be;
            got.source_offset = rsp_mon.source_offset;
            got.bytes_taken   = rsp_mon.bytes_taken;
            got.wide_address  = rsp_mon.wide_address;
            got.last_chunk    = rsp_mon.last_chunk;
            if (expected_chunks.size() == 0) begin
               $error("chunk beat with no chunk expected, address %0h", got.chunk_address);
               fail_count++;
            end else begin
               want = expected_chunks.pop_front();
               check_field("chunk_address", want.chunk_address, got.chunk_address);
               check_field("length_dwords", want.length_dwords, got.length_dwords);
               check_field("first_be", want.first_be, got.first_be);
               check_field("last_be", want.last_be, got.last_be);
               check_field("source_offset", want.source_offset, got.source_offset);
               check_field("bytes_taken", want.bytes_taken, got.bytes_taken);
               check_field("wide_address", want.wide_address, got.wide_address);
               check_field("last_chunk", want.last_chunk, got.last_chunk);
            end
         end
         pending = expected_chunks.size();
      end
   end

endmodule

FILE: tb/tb.sv
// Top of the DMA write splitter testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;

   // Cycles still to wait before the sink flips its ready again.
   int unsigned ready_hold;

   dwts_req_if req_ch ();
   dwts_rsp_if rsp_ch ();

   dma_write_tlp_splitter i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // The checker only watches both channels; it never drives them.
   dwts_chunk_checker i_chunk_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // A gap or stall length: mostly none or short, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned sel;
      sel = $urandom_range(0, 19);
      if (sel < 9) return 0;
      if (sel < 15) return $urandom_range(1, 2);
      if (sel < 18) return $urandom_range(3, 6);
      return $urandom_range(15, 40);
   endfunction

   // Addresses spread over the whole 64-bit space, with extra weight on the
   // regions where the interesting edges lie: low memory, just under 4 GiB,
   // just under the top of the address space and on payload boundaries.
   function automatic logic [dwts_pkg::ADDR_W-1:0] pick_address();
      logic [dwts_pkg::ADDR_W-1:0] a;
      int unsigned                 sel;
      a   = {$urandom, $urandom};
      sel = $urandom_range(0, 9);
      if (sel >= 4 && sel <= 6) begin
         a[dwts_pkg::ADDR_W-1:32] = '0;
      end else if (sel == 7) begin
         a = 64'h1_0000_0000 - dwts_pkg::ADDR_W'($urandom_range(0, 300));
      end else if (sel == 8) begin
         a = 64'h0 - dwts_pkg::ADDR_W'($urandom_range(1, 300));
      end else if (sel == 9) begin
         a[dwts_pkg::PAYLOAD_BITS-1:0] =
            ($urandom_range(0, 1) == 0) ?
            dwts_pkg::PAYLOAD_BITS'($urandom_range(0, 3)) :
            dwts_pkg::PAYLOAD_BITS'(dwts_pkg::MAX_PAYLOAD - $urandom_range(1, 4));
      end
      return a;
   endfunction

   // Byte counts: most are small so that the run stays quick, a good share
   // crosses one or two payload boundaries, and a few are full-size.
   function automatic logic [dwts_pkg::COUNT_W-1:0] pick_count();
      int unsigned sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) return '0;
      if (sel == 1) return dwts_pkg::COUNT_W'(dwts_pkg::MAX_BYTES);
      if (sel < 9) return dwts_pkg::COUNT_W'($urandom_range(1, 16));
      if (sel < 16) return dwts_pkg::COUNT_W'($urandom_range(17, 300));
      return dwts_pkg::COUNT_W'($urandom_range(301, dwts_pkg::MAX_BYTES));
   endfunction

   // Offers one request beat after a random gap and holds it until it is taken.
   // When there is no gap, valid simply stays high into the next beat.
   task automatic send_request(input logic [dwts_pkg::ADDR_W-1:0] addr,
                               input logic [dwts_pkg::COUNT_W-1:0] count);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.start_address <= addr;
      req_ch.byte_count    <= count;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // The result sink alternates between ready stretches and stalls of random
   // length. Now and then a long ready stretch lets the block run flat out.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         ready_hold   <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_ch.ready) begin
         rsp_ch.ready <= 1'b0;
         ready_hold   <= pick_gap();
      end else begin
         rsp_ch.ready <= 1'b1;
         ready_hold   <= ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) :
                                                        $urandom_range(0, 12);
      end
   end

   initial begin
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.start_address = '0;
      req_ch.byte_count    = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests. A zero count must give no chunks at all.
      send_request(64'h0, 13'd0);
      // Short requests that sit inside one dword, aligned and unaligned.
      send_request(64'h0, 13'd1);
      send_request(64'h3, 13'd1);
      send_request(64'h1, 13'd2);
      send_request(64'h2, 13'd2);
      send_request(64'h1, 13'd3);
      // An unaligned head followed by a short aligned tail.
      send_request(64'h2, 13'd5);
      send_request(64'h0, 13'd4);
      send_request(64'h0, 13'd5);
      // Exactly one payload, and one byte beyond it.
      send_request(64'h0, 13'd128);
      send_request(64'h0, 13'd129);
      // Requests that meet or straddle a payload boundary.
      send_request(64'h7c, 13'd8);
      send_request(64'h7e, 13'd4);
      send_request(64'h7f, 13'd2);
      send_request(64'h80, 13'd3);
      // Full-size requests; the unaligned one gives the most chunks.
      send_request(64'h1, 13'd4096);
      send_request(64'h0, 13'd4096);
      send_request(64'h40, 13'd4096);
      // Crossing the 4 GiB line, and wrapping past the top of the address space.
      send_request(64'hffff_fff0, 13'd64);
      send_request(64'hffff_ffff_ffff_fff3, 13'd40);
      send_request(64'hffff_ffff_ffff_ffff, 13'd1);
      // Counts above the maximum are clipped to it.
      send_request(64'h1000, 13'd4097);
      send_request(64'h5, 13'h1fff);

      // Random requests.
      repeat (147) send_request(pick_address(), pick_count());
      req_ch.valid <= 1'b0;

      // Let the checker see the last request beat, drain every chunk and
      // give the block time to settle after the final one.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run with the longest stalls.
   initial begin
      #40_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
